// File: sv/gffrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_pkg
// Shared types and constants of the first-fit rectangle placer: beat
// payloads, result status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gffrp_pkg;

  // default grid size
  localparam int GRID_W_DEF = 8;
  localparam int GRID_H_DEF = 15;

  // placed counter saturation value
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // request opcodes
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_CLEARED = 2'd2
  } status_t;

  // input beat
  typedef struct packed {
    logic       op;
    logic [3:0] rect_width;
    logic [3:0] rect_height;
  } in_t;

  // output beat
  typedef struct packed {
    status_t    status;
    logic [6:0] anchor_index;
    logic [6:0] placed_count;
  } out_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_step;
    logic mark;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_clear;
    logic size_zero;
    logic scan_last;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// File: sv/gffrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_ctrl
// Sequencer of the placer: takes a request, runs the row scan and the marking
// step for a non-empty place, and the result load into the output register.
// ----------------------------------------------------------------------------
module gffrp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gffrp_pkg::sts_t sts,
  output gffrp_pkg::cmd_t cmd
);

  gffrp_pkg::state_t state;
  gffrp_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gffrp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      gffrp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = gffrp_pkg::S_DECODE;
        end
      end
      gffrp_pkg::S_DECODE: begin
        if (sts.op_clear) begin
          cmd.clear  = 1'b1;
          state_next = gffrp_pkg::S_DONE;
        end else if (sts.size_zero) begin
          state_next = gffrp_pkg::S_DONE;
        end else begin
          state_next = gffrp_pkg::S_SCAN;
        end
      end
      gffrp_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = gffrp_pkg::S_MARK;
        end
      end
      gffrp_pkg::S_MARK: begin
        cmd.mark   = sts.found;
        state_next = gffrp_pkg::S_DONE;
      end
      gffrp_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = gffrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gffrp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/gffrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_dp
// Datapath of the placer: occupancy rows, per-column free-run counters for
// the bottom-up row scan, the best anchor so far, the placed counter and
// the output register.
// ----------------------------------------------------------------------------
module gffrp_dp #(
  parameter int GRID_W = gffrp_pkg::GRID_W_DEF,
  parameter int GRID_H = gffrp_pkg::GRID_H_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  gffrp_pkg::in_t  in_data,
  input  gffrp_pkg::cmd_t cmd,
  output gffrp_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output gffrp_pkg::out_t out_data
);

  localparam int XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int RW    = $clog2(GRID_H + 1);
  localparam int CW    = (RW > 4) ? RW : 4;
  localparam int XS    = ((XW > 4) ? XW : 4) + 1;
  localparam int YS    = ((YW > 4) ? YW : 4) + 1;
  localparam int IW    = (GRID_W * GRID_H > 1) ? $clog2(GRID_W * GRID_H) : 1;
  localparam int IDX_W = (IW > 7) ? IW : 7;

  // latched request
  logic       op_q;
  logic [3:0] w_q;
  logic [3:0] h_q;

  // occupancy rows and free-run counters
  logic [GRID_W-1:0] rows [GRID_H];
  logic [RW-1:0]     run  [GRID_W];
  logic [RW-1:0]     run_next [GRID_W];

  logic [YW-1:0] y_q;
  logic          found;
  logic [XW-1:0] best_x;
  logic [YW-1:0] best_y;
  logic [6:0]    count;
  logic [6:0]    count_inc;

  logic [GRID_W-1:0] cur_row;
  logic [GRID_W-1:0] fit;
  logic              fit_any;
  logic [XW-1:0]     fit_x;
  logic [GRID_W-1:0] mark_mask;
  logic [GRID_H-1:0] mark_rows;
  logic [IDX_W-1:0]  anchor_full;
  gffrp_pkg::out_t   out_next;

  // status toward the controller
  assign sts.op_clear  = (op_q == gffrp_pkg::OP_CLEAR);
  assign sts.size_zero = (w_q == 4'd0) || (h_q == 4'd0);
  assign sts.scan_last = (y_q == '0);
  assign sts.found     = found;
  assign sts.out_free  = !out_valid || out_ready;

  // free runs with the current row on top, and anchor fits in that row
  always_comb begin
    cur_row = rows[y_q];
    for (int c = 0; c < GRID_W; c++) begin
      run_next[c] = cur_row[c] ? '0 : run[c] + RW'(1);
    end
    for (int x = 0; x < GRID_W; x++) begin
      fit[x] = (XS'(x) + XS'(w_q) <= XS'(GRID_W));
      for (int c = 0; c < GRID_W; c++) begin
        if (c >= x && XS'(c) < XS'(x) + XS'(w_q) && CW'(run_next[c]) < CW'(h_q)) begin
          fit[x] = 1'b0;
        end
      end
    end
    fit_any = |fit;
    fit_x   = '0;
    for (int x = GRID_W - 1; x >= 0; x--) begin
      if (fit[x]) begin
        fit_x = XW'(x);
      end
    end
  end

  // cells covered by the chosen rectangle
  always_comb begin
    for (int c = 0; c < GRID_W; c++) begin
      mark_mask[c] = (XS'(c) >= XS'(best_x)) && (XS'(c) < XS'(best_x) + XS'(w_q));
    end
    for (int r = 0; r < GRID_H; r++) begin
      mark_rows[r] = (YS'(r) >= YS'(best_y)) && (YS'(r) < YS'(best_y) + YS'(h_q));
    end
  end

  // result beat
  always_comb begin
    count_inc   = (count == gffrp_pkg::COUNT_MAX) ? count : count + 7'd1;
    anchor_full = IDX_W'(best_x) + IDX_W'(best_y) * IDX_W'(GRID_W);
    if (op_q == gffrp_pkg::OP_CLEAR) begin
      out_next.status       = gffrp_pkg::ST_CLEARED;
      out_next.anchor_index = '0;
      out_next.placed_count = '0;
    end else if (found) begin
      out_next.status       = gffrp_pkg::ST_PLACED;
      out_next.anchor_index = anchor_full[6:0];
      out_next.placed_count = count_inc;
    end else begin
      out_next.status       = gffrp_pkg::ST_NOROOM;
      out_next.anchor_index = '0;
      out_next.placed_count = count;
    end
  end

  // control registers: map, counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      for (int r = 0; r < GRID_H; r++) begin
        rows[r] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        count <= '0;
        for (int r = 0; r < GRID_H; r++) begin
          rows[r] <= '0;
        end
      end
      if (cmd.mark) begin
        for (int r = 0; r < GRID_H; r++) begin
          if (mark_rows[r]) begin
            rows[r] <= rows[r] | mark_mask;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (op_q == gffrp_pkg::OP_PLACE && found) begin
          count <= count_inc;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_data.op;
      w_q   <= in_data.rect_width;
      h_q   <= in_data.rect_height;
      y_q   <= YW'(GRID_H - 1);
      found <= 1'b0;
      for (int c = 0; c < GRID_W; c++) begin
        run[c] <= '0;
      end
    end
    if (cmd.scan_step) begin
      y_q <= y_q - YW'(1);
      for (int c = 0; c < GRID_W; c++) begin
        run[c] <= run_next[c];
      end
      if (fit_any) begin
        found  <= 1'b1;
        best_x <= fit_x;
        best_y <= y_q;
      end
    end
    if (cmd.out_load) begin
      out_data <= out_next;
    end
  end

endmodule

// File: sv/grid_first_fit_rect_placer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer_core
// First-fit rectangle placer on a GRID_W by GRID_H occupancy grid.
// ----------------------------------------------------------------------------
// A clear request goes from decode straight to the done state; a place request
// runs the scan and mark states in between, and a zero-size place skips them. The
// scan walks the occupancy rows from the bottom up, one row a cycle, keeping a
// free-run count per column, so every anchor in a row is checked in the cycle
// that row is read; the last fitting row seen, the topmost, is the first-fit
// anchor. The covered cells are then marked in the mark state. One request is in
// flight at a time; the next one is taken while the result still waits in the
// output register. The map clears at reset with no extra pass.
module grid_first_fit_rect_placer_core #(
  parameter int GRID_W = gffrp_pkg::GRID_W_DEF,
  parameter int GRID_H = gffrp_pkg::GRID_H_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gffrp_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gffrp_pkg::out_t out_data
);

  gffrp_pkg::cmd_t cmd;
  gffrp_pkg::sts_t sts;

  // sequencer
  gffrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // map and scan datapath
  gffrp_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/gffrp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_chk
// Port-level checks of the placer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gffrp_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input gffrp_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input gffrp_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // anchor index is zero unless placed
  a_anchor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != gffrp_pkg::ST_PLACED |-> out_data.anchor_index == 7'd0)
    else $error("anchor index set on a result that placed nothing");

  // clear result reports an empty count
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == gffrp_pkg::ST_CLEARED |-> out_data.placed_count == 7'd0)
    else $error("clear result with nonzero count");

endmodule

bind grid_first_fit_rect_placer_core gffrp_chk u_chk (.*);
